FILE: design/mss_pkg.sv
// Shared types and constants for the masked signature scan block.
package mss_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 64;
  localparam int unsigned BLOCK_BYTES_DEF = 4096;
  localparam int unsigned TAIL_BYTES_DEF  = 64;

  localparam int unsigned POS_W  = 6;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LEN_W  = 7;

  typedef enum logic [2:0] {
    CL_LIT  = 3'd0,
    CL_WILD = 3'd1,
    CL_ABS  = 3'd2,
    CL_RAW  = 3'd3,
    CL_BYTE = 3'd4
  } class_e;

  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_BLOCK  = 2'd1,
    REG_BASE   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic              is_data;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
    class_e            cls;
    logic              last;
  } item_t;

endpackage

FILE: design/mss_front.sv
// Input stage: takes transfers, drops out-of-range loads and normalizes entry classes.
module mss_front import mss_pkg::*; #(
  parameter int unsigned PatternMax = PATTERN_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] byte_value_i,
  input  logic [2:0]        entry_class_i,
  input  logic              last_i,
  output logic              push_o,
  output item_t             item_o,
  input  logic              q_ready_i
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  keep;
  logic  take;

  assign in_ready_o = !valid_q || q_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign keep       = kind_i || (int'(position_i) < PatternMax);
  assign push_o     = valid_q;
  assign item_o     = item_q;

  always_comb begin
    item_d.is_data = kind_i;
    item_d.pos     = position_i;
    item_d.data    = byte_value_i;
    item_d.last    = last_i;
    unique case (entry_class_i)
      3'd0:    item_d.cls = CL_LIT;
      3'd1:    item_d.cls = CL_WILD;
      3'd2:    item_d.cls = CL_ABS;
      3'd3:    item_d.cls = CL_RAW;
      3'd4:    item_d.cls = CL_BYTE;
      default: item_d.cls = CL_WILD;
    endcase
    valid_d = valid_q && !q_ready_i;
    if (take) begin
      valid_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: design/mss_fifo.sv
// Two-entry queue between the input stage and the scan core.
module mss_fifo import mss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: design/mss_back.sv
// Scan core: pattern store, byte window, parallel compare, field extraction, result register.
module mss_back import mss_pkg::*; #(
  parameter int unsigned PatternMax = PATTERN_MAX_DEF,
  parameter int unsigned BlockBytes = BLOCK_BYTES_DEF,
  parameter int unsigned TailBytes  = TAIL_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [VAL_W-1:0] cfg_data_i,
  input  logic             q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             found_o,
  output logic [VAL_W-1:0] value_o
);

  localparam int unsigned PW  = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int unsigned LW  = $clog2(PatternMax + 1);
  localparam int unsigned Cap = BlockBytes + TailBytes;
  localparam int unsigned CW  = $clog2(Cap + 1);
  localparam int unsigned NW  = $clog2(Cap + PatternMax + 5);

  logic [DATA_W-1:0] pb_q  [PatternMax];
  class_e            pc_q  [PatternMax];
  logic [DATA_W-1:0] win_q [PatternMax];
  logic [DATA_W-1:0] win_n [PatternMax];

  logic [CW-1:0]    cnt_q, cnt_d, cnt_n;
  logic [CW-1:0]    start_q, start_d;
  logic             found_q, found_d;
  logic             rdy_q, rdy_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic [LEN_W-1:0] len_q;
  logic [VAL_W-1:0] baddr_q, mbase_q;
  logic             ovalid_q, ovalid_d;
  logic             ofound_q, ofound_d;
  logic [VAL_W-1:0] ovalue_q, ovalue_d;

  logic             out_free, pop, is_data, stored;
  logic [LW-1:0]    len_use;
  logic [PW-1:0]    fl, fpos;
  logic             have_byte, have_raw, have_abs, lit_seen;
  logic             hit, bound_ok, match_ok;
  logic [CW-1:0]    s_new, s_eff;
  logic             found_eff, rdy_eff, do_ext;
  logic [NW-1:0]    needed, at_idx;
  logic [DATA_W-1:0] bat [4];
  logic [VAL_W-1:0] word, cand;

  assign out_free    = !ovalid_q || out_ready_i;
  assign pop         = q_valid_i && (!q_item_i.is_data || !q_item_i.last || out_free);
  assign q_pop_o     = pop;
  assign is_data     = pop && q_item_i.is_data;
  assign out_valid_o = ovalid_q;
  assign found_o     = ofound_q;
  assign value_o     = ovalue_q;

  always_comb begin
    if (len_q == '0) begin
      len_use = LW'(1);
    end else if (int'(len_q) > PatternMax) begin
      len_use = LW'(PatternMax);
    end else begin
      len_use = LW'(len_q);
    end
  end

  // Window shift, count and the priority search for literal and field positions.
  always_comb begin
    stored = (int'(cnt_q) < Cap);
    cnt_n  = stored ? cnt_q + CW'(1) : cnt_q;
    for (int j = 0; j < PatternMax; j++) begin
      if (!stored) begin
        win_n[j] = win_q[j];
      end else if (j == 0) begin
        win_n[j] = q_item_i.data;
      end else begin
        win_n[j] = win_q[j-1];
      end
    end
    fl = '0;
    lit_seen = 1'b0;
    fpos = '0;
    have_byte = 1'b0;
    have_raw = 1'b0;
    have_abs = 1'b0;
    for (int k = PatternMax - 1; k >= 0; k--) begin
      if (k < int'(len_use)) begin
        if (pc_q[k] == CL_LIT) begin
          fl = PW'(k);
          lit_seen = 1'b1;
        end
      end
    end
    for (int k = PatternMax - 1; k >= 0; k--) begin
      if (k < int'(len_use) && pc_q[k] == CL_ABS) begin
        have_abs = 1'b1;
      end
    end
    for (int k = PatternMax - 1; k >= 0; k--) begin
      if (k < int'(len_use) && pc_q[k] == CL_RAW) begin
        have_raw = 1'b1;
      end
    end
    for (int k = PatternMax - 1; k >= 0; k--) begin
      if (k < int'(len_use) && pc_q[k] == CL_BYTE) begin
        have_byte = 1'b1;
      end
    end
    // Field position: first byte field, else first raw word, else first absolute word.
    for (int k = PatternMax - 1; k >= 0; k--) begin
      if (k < int'(len_use)) begin
        if (have_byte) begin
          if (pc_q[k] == CL_BYTE) fpos = PW'(k);
        end else if (have_raw) begin
          if (pc_q[k] == CL_RAW) fpos = PW'(k);
        end else if (have_abs) begin
          if (pc_q[k] == CL_ABS) fpos = PW'(k);
        end
      end
    end
    if (!lit_seen) begin
      fl = '0;
    end
  end

  // Parallel compare of every literal entry within the pattern length against its window tap.
  always_comb begin
    s_new    = cnt_n - CW'(len_use);
    bound_ok = ((int'(s_new) + int'(fl)) < BlockBytes);
    match_ok = 1'b1;
    for (int k = 0; k < PatternMax; k++) begin
      if (k < int'(len_use) && pc_q[k] == CL_LIT) begin
        if (win_n[PW'(int'(len_use) - 1 - k)] != pb_q[k]) begin
          match_ok = 1'b0;
        end
      end
    end
    hit = stored && !found_q && (int'(cnt_n) >= int'(len_use)) && bound_ok && match_ok;
  end

  // Extraction of the chosen field at the current start.
  always_comb begin
    s_eff     = hit ? s_new : start_q;
    found_eff = found_q || hit;
    rdy_eff   = hit ? 1'b0 : rdy_q;
    if (!have_byte && (have_raw || have_abs)) begin
      needed = NW'(s_eff) + NW'(fpos) + NW'(4);
    end else begin
      needed = '0;
    end
    for (int b = 0; b < 4; b++) begin
      at_idx = NW'(s_eff) + NW'(fpos) + NW'(b);
      if (at_idx < NW'(cnt_n) && (NW'(cnt_n) - at_idx) <= NW'(PatternMax)) begin
        bat[b] = win_n[PW'(NW'(cnt_n) - at_idx - NW'(1))];
      end else begin
        bat[b] = '0;
      end
    end
    word = {bat[3], bat[2], bat[1], bat[0]};
    if (have_byte) begin
      cand = VAL_W'(bat[0]);
    end else if (have_raw) begin
      cand = word;
    end else if (have_abs) begin
      cand = word - mbase_q;
    end else begin
      cand = VAL_W'(s_eff) + baddr_q - mbase_q;
    end
    do_ext = found_eff && !rdy_eff && (NW'(cnt_n) >= needed);
  end

  always_comb begin
    cnt_d    = cnt_q;
    start_d  = start_q;
    found_d  = found_q;
    rdy_d    = rdy_q;
    value_d  = value_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ofound_d = ofound_q;
    ovalue_d = ovalue_q;
    if (is_data) begin
      cnt_d   = cnt_n;
      start_d = s_eff;
      found_d = found_eff;
      rdy_d   = rdy_eff || do_ext;
      value_d = do_ext ? cand : value_q;
      if (q_item_i.last) begin
        ovalid_d = 1'b1;
        ofound_d = found_eff;
        ovalue_d = found_eff ? (rdy_eff ? value_q : cand) : '0;
        cnt_d    = '0;
        start_d  = '0;
        found_d  = 1'b0;
        rdy_d    = 1'b0;
        value_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      start_q  <= '0;
      found_q  <= 1'b0;
      rdy_q    <= 1'b0;
      value_q  <= '0;
      ovalid_q <= 1'b0;
      len_q    <= LEN_W'(1);
      baddr_q  <= '0;
      mbase_q  <= '0;
    end else begin
      cnt_q    <= cnt_d;
      start_q  <= start_d;
      found_q  <= found_d;
      rdy_q    <= rdy_d;
      value_q  <= value_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LENGTH: len_q   <= cfg_data_i[LEN_W-1:0];
          REG_BLOCK:  baddr_q <= cfg_data_i;
          REG_BASE:   mbase_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ofound_q <= ofound_d;
    ovalue_q <= ovalue_d;
    if (is_data) begin
      for (int j = 0; j < PatternMax; j++) begin
        win_q[j] <= win_n[j];
      end
    end
    if (pop && !q_item_i.is_data) begin
      for (int j = 0; j < PatternMax; j++) begin
        if (int'(q_item_i.pos) == j) begin
          pb_q[j] <= q_item_i.data;
          pc_q[j] <= q_item_i.cls;
        end
      end
    end
  end

endmodule

FILE: design/masked_signature_scan.sv
// Top level of the masked signature scan: wildcard byte pattern search over a streamed block.
//
// Usage: configuration writes (pattern length, block address, module base) go through the
// cfg_we_i / cfg_idx_i / cfg_data_i port while the block is idle. Items arrive on the input
// valid/ready channel. A load item (kind 0) writes one pattern entry; a data item (kind 1)
// carries one byte of the scanned block, and the byte with last set ends the block.
// Every pattern position is compared in parallel against a shift window of recent bytes,
// so the block sustains one transfer per clock cycle, loads and data alike, unless the receiver stalls.
// For each data byte with last set, exactly one result transfer (found, value) leaves on the
// output valid/ready channel; the byte passes the input stage register and the two-entry queue,
// and the result is held in the result register until the receiver takes it.
// The input stage and the scan core are decoupled by the queue; a stalled receiver holds the
// result register, the scan core then stops at the next last byte, and the queue and input
// stage fill before input ready drops. Loads and ordinary bytes ahead of that byte keep flowing.
// Reset clears the byte count, match state and result valid flag, and sets pattern length to
// one and both addresses to zero. Pattern entries hold no value until they are loaded.
module masked_signature_scan import mss_pkg::*; #(
  parameter int unsigned PatternMax = PATTERN_MAX_DEF,
  parameter int unsigned BlockBytes = BLOCK_BYTES_DEF,
  parameter int unsigned TailBytes  = TAIL_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [VAL_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] byte_value_i,
  input  logic [2:0]        entry_class_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [VAL_W-1:0]  value_o
);

  logic  push, q_ready, q_valid, q_pop;
  item_t front_item, q_item;

  // The input stage drops loads aimed beyond the pattern store and maps unknown classes to
  // wildcards, so the core only sees meaningful entries.
  mss_front #(
    .PatternMax(PatternMax)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .byte_value_i (byte_value_i),
    .entry_class_i(entry_class_i),
    .last_i       (last_i),
    .push_o       (push),
    .item_o       (front_item),
    .q_ready_i    (q_ready)
  );

  mss_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .item_o (q_item),
    .pop_i  (q_pop)
  );

  // The core pops one item per cycle; only a last byte waits for a free result register.
  mss_back #(
    .PatternMax(PatternMax),
    .BlockBytes(BlockBytes),
    .TailBytes (TailBytes)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .found_o    (found_o),
    .value_o    (value_o)
  );

endmodule
